>>> sv/ssd_pkg.sv
// Shared constants, types and the glyph table for the seven-segment serial display driver.
package ssd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int LEN_W = $clog2(DIGIT_COUNT + 1);
  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int FRAME_DEPTH = DIGIT_COUNT + 3;
  localparam int PTR_W = $clog2(FRAME_DEPTH + 1);
  localparam int FIFO_DEPTH = 2;

  localparam int IN_DATA_W = 48;
  localparam int MODE_W = 2;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHOW  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_COLON_ON   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 1'd1;

  typedef enum logic [1:0] {
    BASE_2,
    BASE_10,
    BASE_16
  } base_t;

  typedef logic [DIGIT_COUNT-1:0][7:0] glyph_vec_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              lz;
    base_t             base;
    logic [LEN_W-1:0]  len;
    logic [1:0]        pos;
    logic [15:0]       q;
    glyph_vec_t        glyphs;
  } ssd_stage_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  len;
    logic [1:0]        pos;
    glyph_vec_t        glyphs;
  } ssd_item_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } ssd_cfg_t;

  function automatic logic [7:0] ssd_glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'h0:    g = 8'h3F;
      4'h1:    g = 8'h06;
      4'h2:    g = 8'h5B;
      4'h3:    g = 8'h4F;
      4'h4:    g = 8'h66;
      4'h5:    g = 8'h6D;
      4'h6:    g = 8'h7D;
      4'h7:    g = 8'h07;
      4'h8:    g = 8'h7F;
      4'h9:    g = 8'h6F;
      4'hA:    g = 8'h77;
      4'hB:    g = 8'h7C;
      4'hC:    g = 8'h39;
      4'hD:    g = 8'h5E;
      4'hE:    g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

endpackage

>>> sv/ssd_front.sv
// Request cleanup and digit conversion pipeline, one digit per stage.
module ssd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ssd_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [ssd_pkg::MODE_W-1:0]   s_tuser,
  output logic                         item_valid,
  input  logic                         item_ready,
  output ssd_pkg::ssd_item_t           item
);
  import ssd_pkg::*;

  ssd_stage_t                 stage [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0]     stage_valid;
  logic [DIGIT_COUNT-1:0]     stage_ready;
  ssd_stage_t                 load;
  ssd_stage_t                 last;

  logic [15:0] number;
  logic        lz;
  logic [7:0]  radix;
  logic [7:0]  dcount;
  logic [7:0]  spos;

  assign number = s_tdata[15:0];
  assign lz     = s_tdata[16];
  assign radix  = s_tdata[24:17];
  assign dcount = s_tdata[32:25];
  assign spos   = s_tdata[40:33];

  // Produces the glyph of one digit position and the quotient for the next.
  function automatic ssd_stage_t digit_step(input ssd_stage_t s, input logic [IDX_W-1:0] k);
    logic [31:0] prod;
    logic [15:0] qn;
    logic [15:0] rem;
    logic [3:0]  d;
    ssd_stage_t  r;
    r    = s;
    prod = {16'b0, s.q} * 32'd52429;
    rem  = '0;
    case (s.base)
      BASE_2: begin
        qn = {1'b0, s.q[15:1]};
        d  = {3'b0, s.q[0]};
      end
      BASE_10: begin
        qn  = {3'b0, prod[31:19]};
        rem = s.q - ((qn << 3) + (qn << 1));
        d   = rem[3:0];
      end
      default: begin
        qn = {4'b0, s.q[15:4]};
        d  = s.q[3:0];
      end
    endcase
    if (k == '0 || s.q != 16'd0) begin
      r.glyphs[k] = ssd_glyph(d);
    end else begin
      r.glyphs[k] = s.lz ? ssd_glyph(4'h0) : 8'h00;
    end
    r.q = qn;
    return r;
  endfunction

  always_comb begin
    load.mode = s_tuser;
    load.lz   = lz;
    if (radix == 8'd2) begin
      load.base = BASE_2;
    end else if (radix == 8'd10) begin
      load.base = BASE_10;
    end else begin
      load.base = BASE_16;
    end
    if (dcount == 8'd0) begin
      load.len = LEN_W'(1);
    end else if (dcount > 8'(DIGIT_COUNT)) begin
      load.len = LEN_W'(DIGIT_COUNT);
    end else begin
      load.len = dcount[LEN_W-1:0];
    end
    load.pos    = (spos > 8'd3) ? 2'd0 : spos[1:0];
    load.q      = number;
    load.glyphs = '0;
  end

  always_comb begin
    stage_ready[DIGIT_COUNT-1] = !stage_valid[DIGIT_COUNT-1] || item_ready;
    for (int k = DIGIT_COUNT - 2; k >= 0; k--) begin
      stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end
  end

  assign s_tready   = stage_ready[0];
  assign item_valid = stage_valid[DIGIT_COUNT-1];
  assign last       = digit_step(stage[DIGIT_COUNT-1], IDX_W'(DIGIT_COUNT - 1));

  always_comb begin
    item.mode   = last.mode;
    item.len    = last.len;
    item.pos    = last.pos;
    item.glyphs = last.glyphs;
  end

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_stage
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[g] <= 1'b0;
        end else if (stage_ready[g]) begin
          stage_valid[g] <= s_tvalid;
        end
      end
      always_ff @(posedge clk) begin
        if (stage_ready[g]) begin
          stage[g] <= load;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[g] <= 1'b0;
        end else if (stage_ready[g]) begin
          stage_valid[g] <= stage_valid[g-1];
        end
      end
      always_ff @(posedge clk) begin
        if (stage_ready[g]) begin
          stage[g] <= digit_step(stage[g-1], IDX_W'(g - 1));
        end
      end
    end
  end

endmodule

>>> sv/ssd_fifo.sv
// Short queue between the conversion pipeline and the wire sequencer.
module ssd_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  ssd_pkg::ssd_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output ssd_pkg::ssd_item_t pop_item
);
  import ssd_pkg::*;

  localparam int FPTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

  ssd_item_t         mem [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr;
  logic [FPTR_W-1:0] rd_ptr;
  logic [FCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != FCNT_W'(FIFO_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + FCNT_W'(1);
        2'b01:   count <= count - FCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> sv/ssd_back.sv
// Wire sequencer: frame storage, start/byte/stop phase control and output register.
module ssd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ssd_pkg::ssd_cfg_t             cfg,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  ssd_pkg::ssd_item_t            item,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ssd_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ssd_pkg::*;

  localparam int FIDX_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam logic [7:0] CMD_AUTO  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_CTRL  = 8'h88;
  localparam logic [7:0] COLON_BIT = 8'h80;
  localparam logic [4:0] PH_BITS_END  = 5'd24;
  localparam logic [4:0] PH_RELEASE   = 5'd25;
  localparam logic [4:0] PH_ACK_CLK   = 5'd26;
  localparam logic [4:0] PH_DRIVE_LOW = 5'd27;
  localparam logic [4:0] PH_LAST      = 5'd28;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WRITE,
    ST_STOP
  } state_t;

  state_t           state, state_next;
  logic [PTR_W-1:0] byte_total, byte_total_next;
  logic [PTR_W-1:0] byte_ptr, byte_ptr_next;
  logic [4:0]       phase, phase_next;
  logic             clock_level, clock_level_next;
  logic             data_level, data_level_next;
  logic             data_driven, data_driven_next;
  logic             colon_on;
  logic [2:0]       brightness;

  logic [7:0]       frame [FRAME_DEPTH];
  logic [7:0]       frame_wdata [FRAME_DEPTH];
  logic [FRAME_DEPTH-1:0] frame_we;

  logic             go;
  logic             load;
  logic             tick;
  logic             is_clear;
  logic [LEN_W-1:0] ld_len;
  logic [PTR_W-1:0] ld_len_p;
  logic [1:0]       ld_pos;
  logic [7:0]       cur_byte;
  logic [8:0]       div_prod;
  logic [2:0]       bit_sel;
  logic [4:0]       sub5;
  logic             ends_frame;

  assign item_ready = !m_tvalid || m_tready;
  assign go         = item_valid && item_ready;
  assign is_clear   = item.mode == MODE_CLEAR;
  assign load       = go && state == ST_IDLE && (item.mode == MODE_SHOW || is_clear);
  assign tick       = go && item.mode == MODE_TICK;
  assign ld_len     = is_clear ? LEN_W'(DIGIT_COUNT) : item.len;
  assign ld_len_p   = PTR_W'(ld_len);
  assign ld_pos     = is_clear ? 2'd0 : item.pos;

  assign cur_byte = frame[byte_ptr[FIDX_W-1:0]];
  assign div_prod = {4'b0, phase} * 9'd11;
  assign bit_sel  = div_prod[7:5];
  assign sub5     = phase - {1'b0, bit_sel, 1'b0} - {2'b0, bit_sel};

  assign ends_frame = byte_ptr == '0
                   || {1'b0, byte_ptr} + (PTR_W + 1)'(2) == {1'b0, byte_total}
                   || {1'b0, byte_ptr} + (PTR_W + 1)'(1) == {1'b0, byte_total};

  always_comb begin
    logic [PTR_W-1:0] jj;
    logic [PTR_W-1:0] kk;
    for (int j = 0; j < FRAME_DEPTH; j++) begin
      jj = PTR_W'(j);
      kk = ld_len_p + PTR_W'(1) - jj;
      frame_we[j]    = 1'b1;
      frame_wdata[j] = 8'h00;
      if (j == 0) begin
        frame_wdata[j] = CMD_AUTO;
      end else if (j == 1) begin
        frame_wdata[j] = CMD_ADDR | {6'b0, ld_pos};
      end else if (jj < ld_len_p + PTR_W'(2)) begin
        if (!is_clear) begin
          frame_wdata[j] = item.glyphs[kk[IDX_W-1:0]] | (colon_on ? COLON_BIT : 8'h00);
        end
      end else if (jj == ld_len_p + PTR_W'(2)) begin
        frame_wdata[j] = CMD_CTRL | {5'b0, brightness};
      end else begin
        frame_we[j] = 1'b0;
      end
    end
  end

  always_comb begin
    state_next       = state;
    byte_total_next  = byte_total;
    byte_ptr_next    = byte_ptr;
    phase_next       = phase;
    clock_level_next = clock_level;
    data_level_next  = data_level;
    data_driven_next = data_driven;
    if (load) begin
      byte_total_next = ld_len_p + PTR_W'(3);
      byte_ptr_next   = '0;
      phase_next      = '0;
      state_next      = ST_START;
    end else if (tick) begin
      case (state)
        ST_START: begin
          data_level_next  = 1'b0;
          data_driven_next = 1'b1;
          state_next       = ST_WRITE;
          phase_next       = '0;
        end
        ST_WRITE: begin
          if (phase < PH_BITS_END) begin
            case (sub5[1:0])
              2'd0: clock_level_next = 1'b0;
              2'd1: begin
                data_level_next  = cur_byte[bit_sel];
                data_driven_next = 1'b1;
              end
              default: clock_level_next = 1'b1;
            endcase
          end else if (phase == PH_RELEASE) begin
            data_driven_next = 1'b0;
          end else if (phase == PH_ACK_CLK) begin
            clock_level_next = 1'b1;
          end else if (phase == PH_DRIVE_LOW) begin
            data_driven_next = 1'b1;
            data_level_next  = 1'b0;
          end else begin
            clock_level_next = 1'b0;
          end
          if (phase == PH_LAST) begin
            phase_next = '0;
            if (ends_frame) begin
              state_next = ST_STOP;
            end else begin
              byte_ptr_next = byte_ptr + PTR_W'(1);
            end
          end else begin
            phase_next = phase + 5'd1;
          end
        end
        ST_STOP: begin
          if (phase == 5'd0) begin
            data_level_next  = 1'b0;
            data_driven_next = 1'b1;
            phase_next       = 5'd1;
          end else if (phase == 5'd1) begin
            clock_level_next = 1'b1;
            phase_next       = 5'd2;
          end else begin
            data_level_next  = 1'b1;
            data_driven_next = 1'b1;
            phase_next       = '0;
            if ({1'b0, byte_ptr} + (PTR_W + 1)'(1) >= {1'b0, byte_total}) begin
              state_next = ST_IDLE;
            end else begin
              byte_ptr_next = byte_ptr + PTR_W'(1);
              state_next    = ST_START;
            end
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      byte_total  <= '0;
      byte_ptr    <= '0;
      phase       <= '0;
      clock_level <= 1'b1;
      data_level  <= 1'b1;
      data_driven <= 1'b1;
      colon_on    <= 1'b0;
      brightness  <= 3'd7;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          REG_COLON_ON:   colon_on   <= cfg.data[0];
          REG_BRIGHTNESS: brightness <= cfg.data[2:0];
          default:        colon_on   <= colon_on;
        endcase
      end
      if (go) begin
        state       <= state_next;
        byte_total  <= byte_total_next;
        byte_ptr    <= byte_ptr_next;
        phase       <= phase_next;
        clock_level <= clock_level_next;
        data_level  <= data_level_next;
        data_driven <= data_driven_next;
        m_tvalid    <= 1'b1;
        m_tdata     <= {3'b0, load, state_next != ST_IDLE, data_driven_next,
                        data_driven_next & data_level_next, clock_level_next};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < FRAME_DEPTH; j++) begin
        if (frame_we[j]) begin
          frame[j] <= frame_wdata[j];
        end
      end
    end
  end

endmodule

>>> sv/seven_segment_serial_display_driver.sv
// Top level of the seven-segment serial display driver.
// A transaction's result passes through the four conversion stages, the queue,
// and the output register.
// Throughput: one transaction per cycle, limited only by the output handshake.
// Reset is synchronous and active high; it empties the pipeline and queue, sets the
// sequencer idle with both lines high, clears colon_on and sets brightness to 7.
module seven_segment_serial_display_driver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // number, leading_zeros, radix, digit_count, start_position
  input  logic [ssd_pkg::IN_DATA_W-1:0]   s_tdata,
  // mode
  input  logic [ssd_pkg::MODE_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // clock_pin, data_pin, data_drive, busy_res, accepted
  output logic [ssd_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_we,
  input  logic [ssd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ssd_pkg::*;

  ssd_item_t front_item;
  logic      front_valid;
  logic      front_ready;
  ssd_item_t back_item;
  logic      back_valid;
  logic      back_ready;
  ssd_cfg_t  cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  ssd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  ssd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  ssd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .item       (back_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the seven-segment serial display driver.
`timescale 1ns / 1ps

module tb_top;
  import ssd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam logic [7:0] CMD_AUTO_INC = 8'h40;
  localparam logic [7:0] CMD_ADDRESS = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY = 8'h88;
  localparam logic [7:0] COLON_SEG = 8'h80;
  localparam int WRITE_PHASES = 29;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int QUIET_TAIL = 150;
  localparam int DIR_N = 18;

  localparam logic [15:0][7:0] SEG_GLYPH = {
    8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_WRITE,
    SEQ_STOP
  } seq_stage_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [15:0]       number;
    logic              lz;
    logic [7:0]        radix;
    logic [7:0]        len;
    logic [7:0]        pos;
  } req_t;

  typedef struct packed {
    logic accepted;
    logic busy_res;
    logic data_drive;
    logic data_pin;
    logic clock_pin;
  } pin_state_t;

  typedef struct packed {
    logic              wcfg;
    logic              colon;
    logic [2:0]        bright;
    logic [MODE_W-1:0] mode;
    logic [15:0]       number;
    logic              lz;
    logic [7:0]        radix;
    logic [7:0]        len;
    logic [7:0]        pos;
    logic              typed;
    logic [4:0]        pins;
    logic              drain;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    '{0, 0, 0, MODE_TICK,  16'h0000, 0, 8'd0,   8'd0,   8'd0,   1, 5'b00111, 0},
    '{0, 0, 0, MODE_NONE,  16'hFFFF, 1, 8'hFF,  8'hFF,  8'hFF,  1, 5'b00111, 0},
    '{0, 0, 0, MODE_SHOW,  16'h0000, 0, 8'd16,  8'd4,   8'd0,   1, 5'b11111, 1},
    '{0, 0, 0, MODE_SHOW,  16'h0000, 1, 8'd10,  8'd4,   8'd3,   1, 5'b11111, 1},
    '{0, 0, 0, MODE_SHOW,  16'hFFFF, 0, 8'd16,  8'd4,   8'd0,   1, 5'b11111, 1},
    '{1, 1, 0, MODE_SHOW,  16'hFFFF, 1, 8'd2,   8'd0,   8'hFF,  1, 5'b11111, 1},
    '{0, 0, 0, MODE_SHOW,  16'd12345, 0, 8'd10, 8'hFF,  8'd2,   1, 5'b11111, 1},
    '{1, 1, 5, MODE_SHOW,  16'h0A5F, 1, 8'd7,   8'd3,   8'd4,   1, 5'b11111, 1},
    '{0, 0, 0, MODE_CLEAR, 16'hFFFF, 1, 8'hFF,  8'hFF,  8'hFF,  1, 5'b11111, 1},
    '{0, 0, 0, MODE_SHOW,  16'h0001, 1, 8'd2,   8'd4,   8'd1,   1, 5'b11111, 0},
    '{0, 0, 0, MODE_SHOW,  16'hFFFF, 1, 8'd10,  8'd4,   8'd3,   0, 5'b00000, 0},
    '{0, 0, 0, MODE_CLEAR, 16'h1234, 0, 8'd16,  8'd2,   8'd1,   0, 5'b00000, 0},
    '{0, 0, 0, MODE_NONE,  16'h00FF, 0, 8'd16,  8'd1,   8'd0,   0, 5'b00000, 0},
    '{0, 0, 0, MODE_TICK,  16'hAAAA, 1, 8'h55,  8'hAA,  8'h55,  0, 5'b00000, 0},
    '{0, 0, 0, MODE_SHOW,  16'h0000, 0, 8'd16,  8'd4,   8'd0,   0, 5'b00000, 1},
    '{1, 1, 7, MODE_SHOW,  16'h0000, 0, 8'd0,   8'd1,   8'd3,   1, 5'b11111, 1},
    '{0, 0, 0, MODE_SHOW,  16'h8000, 0, 8'd2,   8'd4,   8'd0,   1, 5'b11111, 1},
    '{0, 0, 0, MODE_CLEAR, 16'h0000, 0, 8'd10,  8'd4,   8'd2,   1, 5'b11111, 1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [MODE_W-1:0] s_tuser = MODE_TICK;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_COLON_ON;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted display state.
  logic              colon_set = 1'b0;
  logic [2:0]        bright_set = 3'd7;
  logic [7:0]        frame_store [8];
  logic [2:0]        byte_total = '0;
  logic [2:0]        byte_ptr = '0;
  logic [4:0]        phase = '0;
  seq_stage_t        stage = SEQ_IDLE;
  logic              clk_lvl = 1'b1;
  logic              dat_lvl = 1'b1;
  logic              dat_drv = 1'b1;

  pin_state_t expected_pins [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int requests_taken = 0;
  int cfg_settings = 1;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;
  int unsigned gap_rate = 0;
  int unsigned stall_rate = 0;

  seven_segment_serial_display_driver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void load_frames(input glyph_vec_t digits, input int unsigned len,
                                      input int unsigned pos);
    frame_store[0] = CMD_AUTO_INC;
    frame_store[1] = CMD_ADDRESS + 8'(pos & 3);
    for (int i = 0; i < len; i++) frame_store[2 + i] = digits[i];
    frame_store[2 + len] = CMD_DISPLAY + 8'(bright_set);
    byte_total = 3'(len + 3);
    byte_ptr = '0;
    phase = '0;
    stage = SEQ_START;
  endfunction

  function automatic pin_state_t step_display(input req_t r);
    glyph_vec_t digits;
    int unsigned base, len, pos, num, n;
    logic [7:0] fill;
    logic took;
    pin_state_t res;
    took = 1'b0;
    if (r.mode == MODE_TICK) begin
      case (stage)
        SEQ_START: begin
          dat_lvl = 1'b0;
          dat_drv = 1'b1;
          stage = SEQ_WRITE;
          phase = '0;
        end
        SEQ_WRITE: begin
          if (phase < 24) begin
            case (phase % 3)
              0: clk_lvl = 1'b0;
              1: begin
                dat_lvl = frame_store[byte_ptr][phase / 3];
                dat_drv = 1'b1;
              end
              default: clk_lvl = 1'b1;
            endcase
          end else if (phase == 24) begin
            clk_lvl = 1'b0;
          end else if (phase == 25) begin
            dat_drv = 1'b0;
          end else if (phase == 26) begin
            clk_lvl = 1'b1;
          end else if (phase == 27) begin
            dat_drv = 1'b1;
            dat_lvl = 1'b0;
          end else begin
            clk_lvl = 1'b0;
          end
          if (phase + 1 >= WRITE_PHASES) begin
            phase = '0;
            if (byte_ptr == 0 || byte_ptr + 2 == byte_total || byte_ptr + 1 == byte_total)
              stage = SEQ_STOP;
            else
              byte_ptr = byte_ptr + 1'b1;
          end else begin
            phase = phase + 1'b1;
          end
        end
        SEQ_STOP: begin
          if (phase == 0) begin
            dat_lvl = 1'b0;
            dat_drv = 1'b1;
            phase = 5'd1;
          end else if (phase == 1) begin
            clk_lvl = 1'b1;
            phase = 5'd2;
          end else begin
            dat_lvl = 1'b1;
            dat_drv = 1'b1;
            phase = '0;
            if (byte_ptr + 1 >= byte_total) begin
              stage = SEQ_IDLE;
            end else begin
              byte_ptr = byte_ptr + 1'b1;
              stage = SEQ_START;
            end
          end
        end
        default: ;
      endcase
    end else if (r.mode == MODE_SHOW && stage == SEQ_IDLE) begin
      num = r.number;
      fill = r.lz ? SEG_GLYPH[0] : 8'h00;
      base = (r.radix == 2 || r.radix == 10 || r.radix == 16) ? r.radix : 16;
      pos = (r.pos > 3) ? 0 : r.pos;
      len = (r.len > DIGIT_COUNT) ? DIGIT_COUNT : (r.len == 0) ? 1 : r.len;
      digits = '0;
      for (int i = 0; i < len; i++) digits[i] = fill;
      if (num == 0) begin
        digits[len - 1] = SEG_GLYPH[0];
      end else begin
        for (n = 0; n < len && num != 0; n++) begin
          digits[len - 1 - n] = SEG_GLYPH[(num % base) & 15];
          num = num / base;
        end
      end
      for (int i = 0; i < len; i++) digits[i] = digits[i] | (colon_set ? COLON_SEG : 8'h00);
      load_frames(digits, len, pos);
      took = 1'b1;
    end else if (r.mode == MODE_CLEAR && stage == SEQ_IDLE) begin
      load_frames('0, DIGIT_COUNT, 0);
      took = 1'b1;
    end
    if (took) requests_taken++;
    res.clock_pin = clk_lvl;
    res.data_pin = dat_drv ? dat_lvl : 1'b0;
    res.data_drive = dat_drv;
    res.busy_res = (stage != SEQ_IDLE);
    res.accepted = took;
    return res;
  endfunction

  function automatic req_t tick_item();
    req_t r;
    r = req_t'({$urandom, $urandom});
    r.mode = MODE_TICK;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int unsigned k;
    k = $urandom_range(0, 19);
    r.mode = (k < 16) ? MODE_SHOW : (k < 19) ? MODE_CLEAR : MODE_NONE;
    r.lz = $urandom_range(0, 1);
    case ($urandom_range(0, 4))
      0: r.number = 16'h0000;
      1: r.number = 16'($urandom_range(1, 15));
      2: r.number = 16'hFFFF;
      default: r.number = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: r.radix = 8'd2;
      1: r.radix = 8'd10;
      2: r.radix = 8'd16;
      3: r.radix = 8'($urandom);
      default: r.radix = 8'($urandom_range(0, 20));
    endcase
    r.len = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    r.pos = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    return r;
  endfunction

  task automatic send_item(input req_t r, input bit typed, input pin_state_t typed_pins);
    pin_state_t pins;
    if (idle_on && gap_rate != 0 && $urandom_range(0, 15) < gap_rate) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.mode;
    s_tdata <= {7'd0, r.pos, r.len, r.radix, r.lz, r.number};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pins = step_display(r);
    expected_pins.push_back(typed ? typed_pins : pins);
    items_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic colon, input logic [2:0] bright);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLON_ON;
    cfg_data <= {2'b00, colon};
    @(posedge clk);
    cfg_index <= REG_BRIGHTNESS;
    cfg_data <= bright;
    @(posedge clk);
    cfg_we <= 1'b0;
    colon_set = colon;
    bright_set = bright;
    cfg_settings++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && stall_rate != 0 && $urandom_range(0, 15) < stall_rate) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pin_state_t got, want;
    string names [5];
    names = '{"clock_pin", "data_pin", "data_drive", "busy_res", "accepted"};
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[4:0];
      results_seen++;
      if (expected_pins.size() == 0) begin
        $error("result %b arrived with nothing expected", got);
        errors++;
      end else begin
        want = expected_pins.pop_front();
        for (int b = 0; b < 5; b++) begin
          if (got[b] !== want[b]) begin
            $error("%s expected %0d got %0d", names[b], want[b], got[b]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb_top: timeout after %0d cycles without a transaction", STALL_LIMIT);
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t row;
    req_t r;
    int rand_goal;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.wcfg) begin
        settle();
        write_cfg(row.colon, row.bright);
      end
      gap_rate = $urandom_range(0, 4);
      stall_rate = $urandom_range(0, 4);
      r.mode = row.mode;
      r.number = row.number;
      r.lz = row.lz;
      r.radix = row.radix;
      r.len = row.len;
      r.pos = row.pos;
      send_item(r, row.typed, pin_state_t'(row.pins));
      if (row.drain)
        while (stage != SEQ_IDLE) send_item(tick_item(), 1'b0, '0);
    end

    rand_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < rand_goal) begin
      if (rand_goal - items_sent < QUIET_TAIL) idle_on = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 3))
          0: write_cfg(1'b0, 3'd0);
          1: write_cfg(1'b1, 3'd7);
          default: write_cfg($urandom_range(0, 1), $urandom_range(0, 7));
        endcase
      end
      gap_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      stall_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      send_item(random_request(), 1'b0, '0);
      while (stage != SEQ_IDLE) begin
        if ($urandom_range(0, 39) == 0)
          send_item(random_request(), 1'b0, '0);
        else
          send_item(tick_item(), 1'b0, '0);
      end
      repeat ($urandom_range(0, 3)) begin
        r = tick_item();
        if ($urandom_range(0, 3) == 0) r.mode = MODE_NONE;
        send_item(r, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_pins.size() != 0) begin
      $error("%0d results never arrived", expected_pins.size());
      errors += expected_pins.size();
    end
    $display("tb_top: %0d transactions sent, %0d results compared, %0d show or clear taken",
             items_sent, results_seen, requests_taken);
    $display("tb_top: %0d colon and brightness settings used", cfg_settings);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> files.f
sv/ssd_pkg.sv
sv/ssd_front.sv
sv/ssd_fifo.sv
sv/ssd_back.sv
sv/seven_segment_serial_display_driver.sv
tb/tb_top.sv
